/* hw/rtl/dnga_pkg.sv */
// ----------------------------------------------------------------------------
// dnga_pkg
// Shared types and constants for the delayed noise gate with peak AGC.
// ----------------------------------------------------------------------------
package dnga_pkg;

    // Default sizes
    localparam int DelayDepthDefault = 8192;
    localparam int MaxChunkDefault   = 1024;

    // Field widths
    localparam int SampleW = 16;
    localparam int LevelW  = 16;
    localparam int DelayW  = 13;
    localparam int HoldW   = 4;
    localparam int CoolW   = 8;
    localparam int GainW   = 4;
    localparam int KindW   = 2;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;

    // Running peak behavior
    localparam logic [LevelW-1:0] PeakFloor   = 16'd100;
    localparam int                DecayShift  = 6;

    // Saturation bounds
    localparam logic signed [SampleW-1:0] SatMax = 16'sh7FFF;
    localparam logic signed [SampleW-1:0] SatMin = 16'sh8000;

    // Result kinds
    localparam logic [KindW-1:0] KindStatus = 2'd0;
    localparam logic [KindW-1:0] KindPlayed = 2'd1;
    localparam logic [KindW-1:0] KindEmpty  = 2'd2;

    // Action codes
    localparam logic ActPush = 1'b0;
    localparam logic ActPull = 1'b1;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegDelay    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegOpenThr  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegCloseThr = 3'd2;
    localparam logic [CfgIdxW-1:0] RegHold     = 3'd3;
    localparam logic [CfgIdxW-1:0] RegCool     = 3'd4;
    localparam logic [CfgIdxW-1:0] RegTarget   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegLimit    = 3'd6;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_UPDATE,
        S_DIV,
        S_PULL,
        S_EMIT
    } t_state;

endpackage

/* hw/rtl/dnga_div.sv */
// ----------------------------------------------------------------------------
// dnga_div
// Restoring divider, one quotient bit per cycle, for the gain computation.
// ----------------------------------------------------------------------------
module dnga_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dnga_pkg::LevelW-1:0]    i_dividend,
    input  logic [dnga_pkg::LevelW-1:0]    i_divisor,
    output logic                           o_done,
    output logic [dnga_pkg::LevelW-1:0]    o_quotient
);
    import dnga_pkg::*;

    localparam int CntW = $clog2(LevelW + 1);

    logic [LevelW:0]   r_rem, n_rem;
    logic [LevelW-1:0] r_quo, n_quo;
    logic [LevelW-1:0] r_dsr;
    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [LevelW:0]   rem_sh;

    // One restoring step
    always_comb begin
        rem_sh = {r_rem[LevelW-1:0], r_quo[LevelW-1]};
        if (rem_sh >= {1'b0, r_dsr}) begin
            n_rem = rem_sh - {1'b0, r_dsr};
            n_quo = {r_quo[LevelW-2:0], 1'b1};
        end else begin
            n_rem = rem_sh;
            n_quo = {r_quo[LevelW-2:0], 1'b0};
        end
    end

    // Iterate over the dividend bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(LevelW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/dnga_mem.sv */
// ----------------------------------------------------------------------------
// dnga_mem
// Delay memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dnga_mem #(
    parameter int Depth = dnga_pkg::DelayDepthDefault,
    parameter int AddrW = $clog2(Depth)
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AddrW-1:0]                   i_waddr,
    input  logic signed [dnga_pkg::SampleW-1:0] i_wdata,
    input  logic                               i_re,
    input  logic [AddrW-1:0]                   i_raddr,
    output logic signed [dnga_pkg::SampleW-1:0] o_rdata
);
    import dnga_pkg::*;

    logic signed [SampleW-1:0] r_mem [Depth];
    logic signed [SampleW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/delayed_noise_gate_agc_core.sv */
// ----------------------------------------------------------------------------
// delayed_noise_gate_agc_core
// Delay line, chunk peak scan, noise gate and peak-following gain.
// ----------------------------------------------------------------------------
// Usage: push beats (action 0) write one sample to the delay memory when
// chunk and memory have room; a push with chunk_end closes the chunk and
// yields one status beat. Pull beats (action 1) yield one played sample,
// or an empty beat when none pends. Both channels use valid/ready; the
// user must write registers through the plain write port only while the
// block is idle; the block itself does not enforce it. A push without
// chunk_end yields no beat. A pull does the memory read, multiply and
// saturate, and output load; an empty pull only the output load. A chunk
// end runs check, peak scan through the single memory read port, update,
// the bit-serial gain divider when the gate is open, and the output load.
// One item is worked on at a time; input ready is high only in idle.
// Reset clears all control state and loads the register defaults; the
// delay memory is not cleared (only written entries are ever read).
// A stalled receiver holds the result in the output register; the block
// waits with its finished result until the output register frees up.
// ----------------------------------------------------------------------------
module delayed_noise_gate_agc_core #(
    parameter int DELAY_DEPTH = dnga_pkg::DelayDepthDefault,
    parameter int MAX_CHUNK   = dnga_pkg::MaxChunkDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [dnga_pkg::CfgIdxW-1:0]          i_cfg_idx,
    input  logic [dnga_pkg::CfgW-1:0]             i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_action,
    input  logic signed [dnga_pkg::SampleW-1:0]   i_sample_in,
    input  logic                                  i_chunk_end,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [dnga_pkg::KindW-1:0]            o_kind,
    output logic signed [dnga_pkg::SampleW-1:0]   o_sample_out,
    output logic                                  o_last_of_chunk,
    output logic [$clog2(MAX_CHUNK+1)-1:0]        o_play_count,
    output logic                                  o_gate_is_open,
    output logic [dnga_pkg::GainW-1:0]            o_gain_used,
    output logic [dnga_pkg::LevelW-1:0]           o_peak_level
);
    import dnga_pkg::*;

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int FW  = $clog2(DELAY_DEPTH + 1);
    localparam int CW  = $clog2(MAX_CHUNK + 1);
    localparam int M1  = (FW > CW) ? FW : CW;
    localparam int SW  = ((M1 > DelayW) ? M1 : DelayW) + 1;
    localparam int MW  = SampleW + GainW + 1;

    // Configuration registers
    logic [DelayW-1:0] r_delay;
    logic [LevelW-1:0] r_open_thr, r_close_thr, r_target;
    logic [HoldW-1:0]  r_hold_cfg;
    logic [CoolW-1:0]  r_cool_cfg;
    logic [GainW-1:0]  r_limit;

    // Block state
    t_state             r_state, n_state;
    logic [AW-1:0]      r_wr_ptr, r_rd_ptr, r_play_ptr, r_scan_ptr;
    logic [FW-1:0]      r_fill;
    logic [CW-1:0]      r_chunk_len, r_pending, r_take, r_issue;
    logic [LevelW-1:0]  r_run_peak, r_chunk_peak;
    logic               r_gate;
    logic [HoldW-1:0]   r_hold;
    logic [CoolW-1:0]   r_cool;
    logic [GainW-1:0]   r_gain;
    logic               r_rd_pend;

    // Staged result
    logic [KindW-1:0]          r_res_kind;
    logic signed [SampleW-1:0] r_res_sample;
    logic                      r_res_last;
    logic [CW-1:0]             r_res_count;

    // Output register
    logic                      r_ov;
    logic [KindW-1:0]          r_o_kind;
    logic signed [SampleW-1:0] r_o_sample;
    logic                      r_o_last;
    logic [CW-1:0]             r_o_count;
    logic                      r_o_gate;
    logic [GainW-1:0]          r_o_gain;
    logic [LevelW-1:0]         r_o_peak;

    // Datapath wires
    logic                      accept;
    logic                      can_store;
    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_raddr;
    logic signed [SampleW-1:0] mem_rdata;
    logic [SW-1:0]             diff;
    logic [CW-1:0]             take_calc;
    logic [LevelW-1:0]         mag;
    logic [LevelW-1:0]         decayed;
    logic [LevelW-1:0]         peak_next;
    logic                      div_start, div_done;
    logic [LevelW-1:0]         div_quo;
    logic [GainW-1:0]          gain_calc;
    logic signed [MW-1:0]      prod;
    logic signed [SampleW-1:0] sat;
    logic                      emit_load;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == AW'(DELAY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign can_store  = (SW'(r_chunk_len) < SW'(MAX_CHUNK))
                     && (SW'(r_fill) + SW'(r_pending) < SW'(DELAY_DEPTH));
    assign mem_we     = accept && (i_action == ActPush) && can_store;
    assign emit_load  = (r_state == S_EMIT) && (!r_ov || i_out_ready);

    // Chunk take and sample magnitude
    assign diff      = SW'(r_fill) - SW'(r_delay);
    assign take_calc = (diff > SW'(r_chunk_len)) ? r_chunk_len : diff[CW-1:0];
    assign mag       = mem_rdata[SampleW-1] ? LevelW'(-mem_rdata) : LevelW'(mem_rdata);
    assign decayed   = r_run_peak - (r_run_peak >> DecayShift);

    // Running peak after the update: jump up or decay with a floor
    always_comb begin
        if (r_chunk_peak > r_run_peak) begin
            peak_next = r_chunk_peak;
        end else if (decayed < PeakFloor) begin
            peak_next = PeakFloor;
        end else begin
            peak_next = decayed;
        end
    end

    // Gain clamp after the divide
    always_comb begin
        if (div_quo > LevelW'(r_limit)) begin
            gain_calc = r_limit;
        end else begin
            gain_calc = div_quo[GainW-1:0];
        end
        if (gain_calc == '0) begin
            gain_calc = GainW'(1);
        end
    end

    // Gain multiply and saturate
    assign prod = MW'(mem_rdata) * $signed({1'b0, r_gain});
    always_comb begin
        if (prod > MW'(SatMax)) begin
            sat = SatMax;
        end else if (prod < MW'(SatMin)) begin
            sat = SatMin;
        end else begin
            sat = prod[SampleW-1:0];
        end
    end

    // Memory read port select
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_scan_ptr;
        if (r_state == S_IDLE) begin
            mem_raddr = r_play_ptr;
            mem_re    = accept && (i_action == ActPull) && (r_pending != '0);
        end else if (r_state == S_SCAN) begin
            mem_re = (r_issue != r_take);
        end
    end

    assign div_start = (r_state == S_UPDATE) && n_state == S_DIV;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ActPull) begin
                        n_state = (r_pending != '0) ? S_PULL : S_EMIT;
                    end else if (i_chunk_end) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = (SW'(r_fill) < SW'(r_delay)) ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
                if (r_issue == r_take && !r_rd_pend) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_EMIT;
                if (!r_gate) begin
                    if (r_cool == '0 && r_chunk_peak >= r_open_thr) begin
                        n_state = S_DIV;
                    end
                end else if (r_chunk_peak >= r_close_thr || r_hold > HoldW'(1)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_PULL: begin
                if (r_rd_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= DelayW'(1600);
            r_open_thr  <= LevelW'(500);
            r_close_thr <= LevelW'(250);
            r_hold_cfg  <= HoldW'(3);
            r_cool_cfg  <= CoolW'(10);
            r_target    <= LevelW'(28000);
            r_limit     <= GainW'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegDelay:    r_delay     <= i_cfg_data[DelayW-1:0];
                RegOpenThr:  r_open_thr  <= i_cfg_data[LevelW-1:0];
                RegCloseThr: r_close_thr <= i_cfg_data[LevelW-1:0];
                RegHold:     r_hold_cfg  <= i_cfg_data[HoldW-1:0];
                RegCool:     r_cool_cfg  <= i_cfg_data[CoolW-1:0];
                RegTarget:   r_target    <= i_cfg_data[LevelW-1:0];
                RegLimit:    r_limit     <= i_cfg_data[GainW-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_play_ptr  <= '0;
            r_scan_ptr  <= '0;
            r_fill      <= '0;
            r_chunk_len <= '0;
            r_pending   <= '0;
            r_take      <= '0;
            r_issue     <= '0;
            r_run_peak  <= PeakFloor;
            r_chunk_peak <= LevelW'(1);
            r_gate      <= 1'b0;
            r_hold      <= '0;
            r_cool      <= '0;
            r_gain      <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= mem_re;
            case (r_state)
                S_IDLE: begin
                    if (mem_we) begin
                        r_wr_ptr    <= wrap_next(r_wr_ptr);
                        r_fill      <= r_fill + 1'b1;
                        r_chunk_len <= r_chunk_len + 1'b1;
                    end
                end
                S_CHECK: begin
                    r_pending    <= '0;
                    r_chunk_len  <= '0;
                    r_take       <= take_calc;
                    r_issue      <= '0;
                    r_scan_ptr   <= r_rd_ptr;
                    r_chunk_peak <= LevelW'(1);
                end
                S_SCAN: begin
                    if (mem_re) begin
                        r_issue    <= r_issue + 1'b1;
                        r_scan_ptr <= wrap_next(r_scan_ptr);
                    end
                    if (r_rd_pend && mag > r_chunk_peak) begin
                        r_chunk_peak <= mag;
                    end
                end
                S_UPDATE: begin
                    // running peak: jump up or decay with a floor
                    r_run_peak <= peak_next;
                    // gate step
                    if (!r_gate) begin
                        if (r_cool != '0) begin
                            r_cool <= r_cool - 1'b1;
                        end else if (r_chunk_peak >= r_open_thr) begin
                            r_gate <= 1'b1;
                            r_hold <= r_hold_cfg;
                        end
                    end else if (r_chunk_peak >= r_close_thr) begin
                        r_hold <= r_hold_cfg;
                    end else if (r_hold <= HoldW'(1)) begin
                        r_hold <= '0;
                        r_gate <= 1'b0;
                        r_cool <= r_cool_cfg;
                    end else begin
                        r_hold <= r_hold - 1'b1;
                    end
                    if (n_state != S_DIV) begin
                        r_gain <= '0;
                    end
                    // hand the taken samples to playback
                    r_play_ptr <= r_rd_ptr;
                    r_pending  <= r_take;
                    r_rd_ptr   <= r_scan_ptr;
                    r_fill     <= FW'(SW'(r_fill) - SW'(r_take));
                end
                S_DIV: begin
                    if (div_done) begin
                        r_gain <= gain_calc;
                    end
                end
                S_PULL: begin
                    if (r_rd_pend) begin
                        r_play_ptr <= wrap_next(r_play_ptr);
                        r_pending  <= r_pending - 1'b1;
                    end
                end
                S_EMIT: ;
                default: ;
            endcase
        end
    end

    // Stage the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_kind   <= (i_action == ActPull) ? KindEmpty : KindStatus;
            r_res_sample <= '0;
            r_res_last   <= 1'b0;
            r_res_count  <= '0;
        end else if (r_state == S_CHECK) begin
            r_res_count <= (SW'(r_fill) < SW'(r_delay)) ? '0 : take_calc;
        end else if (r_state == S_PULL && r_rd_pend) begin
            r_res_kind   <= KindPlayed;
            r_res_sample <= sat;
            r_res_last   <= (r_pending == CW'(1));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_o_kind   <= r_res_kind;
            r_o_sample <= r_res_sample;
            r_o_last   <= r_res_last;
            if (r_res_kind == KindStatus) begin
                r_o_count <= r_res_count;
                r_o_gate  <= r_gate;
                r_o_gain  <= r_gain;
                r_o_peak  <= r_run_peak;
            end else begin
                r_o_count <= '0;
                r_o_gate  <= 1'b0;
                r_o_gain  <= '0;
                r_o_peak  <= '0;
            end
        end
    end

    assign o_out_valid     = r_ov;
    assign o_kind          = r_o_kind;
    assign o_sample_out    = r_o_sample;
    assign o_last_of_chunk = r_o_last;
    assign o_play_count    = r_o_count;
    assign o_gate_is_open  = r_o_gate;
    assign o_gain_used     = r_o_gain;
    assign o_peak_level    = r_o_peak;

    dnga_mem #(
        .Depth (DELAY_DEPTH),
        .AddrW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_sample_in),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Divisor is the running peak value written in the update cycle
    dnga_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_target),
        .i_divisor  (peak_next),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

endmodule
